[rtl/core/int4_block_dequant_dot_product_defines.svh]
// Assertion macros for the checker file of the int4 block dequant dot product.
// Depends on nothing; each file that asserts includes it by name.
`ifndef INT4_BLOCK_DEQUANT_DOT_PRODUCT_DEFINES_SVH
`define INT4_BLOCK_DEQUANT_DOT_PRODUCT_DEFINES_SVH

// Plain property, sampled on clk_i, muted while rst_ni is low.
`define I4DQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, sampled on clk_i, muted while rst_ni is low.
`define I4DQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/core/i4dq_pkg.sv]
// Shared constants and types of the int4 block dequant dot product.
// Used by every module of the block; depends on nothing.
package i4dq_pkg;

  localparam int BLOCK_ELEMS = 32;
  localparam int BPB         = (BLOCK_ELEMS / 2 < 1) ? 1 : BLOCK_ELEMS / 2;
  localparam int CNT_W       = (BPB > 1) ? $clog2(BPB) : 1;

  localparam int NIB_W   = 4;
  localparam int WOFF_W  = NIB_W + 1;
  localparam int ACT_W   = 16;
  localparam int PAIR_W  = 21;
  localparam int BSUM_W  = 25;
  localparam int PROD_W  = BSUM_W + ACT_W;
  localparam int ROW_W   = 48;

  localparam logic signed [WOFF_W-1:0] NIB_OFFSET = 5'sd8;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic signed [PAIR_W-1:0] pair_sum;
    logic signed [ACT_W-1:0]  scale;
    logic                     close;
    logic                     last;
  } i4dq_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } i4dq_qstat_t;

endpackage

[rtl/core/int4_block_dequant_dot_product.sv]
// int4 block dequant dot product: one packed weight byte and two activations per item.
// Throughput one item per cycle; the front takes an item whenever the four-entry queue has room.
// A last item is written into the queue on its accepting edge, then passes through
// block sum, scale multiply and row total into the output register.
// rst_ni (asynchronous, active low) empties the queue and clears block sum, byte count
// and row total to zero; no clearing pass follows.
module int4_block_dequant_dot_product import i4dq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [7:0]              weight_pair_i,
  input  logic signed [ACT_W-1:0] act_even_i,
  input  logic signed [ACT_W-1:0] act_odd_i,
  input  logic signed [ACT_W-1:0] block_scale_i,
  input  logic                    last_of_row_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [ROW_W-1:0] dot_result_o
);

  // queue status travels back to both sides as one bundle
  i4dq_qstat_t qstat;
  i4dq_entry_t wr_data;
  i4dq_entry_t rd_data;
  logic        wr_en;
  logic        rd_en;

  // front: offset both nibbles by eight, multiply by their activations,
  // and tag the item that closes a block (full block or end of row)
  i4dq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .weight_pair_i (weight_pair_i),
    .act_even_i    (act_even_i),
    .act_odd_i     (act_odd_i),
    .block_scale_i (block_scale_i),
    .last_of_row_i (last_of_row_i),
    .qstat_i       (qstat),
    .wr_en_o       (wr_en),
    .wr_data_o     (wr_data)
  );

  // queue: absorb items while the back holds on a stalled result
  i4dq_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_data_o (rd_data),
    .qstat_o   (qstat)
  );

  // back: saturate the block sum, scale it when the block closes,
  // fold it into the saturated row total and present the total on last
  i4dq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .qstat_i      (qstat),
    .rd_data_i    (rd_data),
    .rd_en_o      (rd_en),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .dot_result_o (dot_result_o)
  );

endmodule

[rtl/core/i4dq_front.sv]
// Front end: accepts items, forms the two offset-weight products and tags block close.
// Depends on i4dq_pkg; feeds i4dq_queue.
module i4dq_front import i4dq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [7:0]              weight_pair_i,
  input  logic signed [ACT_W-1:0] act_even_i,
  input  logic signed [ACT_W-1:0] act_odd_i,
  input  logic signed [ACT_W-1:0] block_scale_i,
  input  logic                    last_of_row_i,
  input  i4dq_qstat_t             qstat_i,
  output logic                    wr_en_o,
  output i4dq_entry_t             wr_data_o
);

  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic signed [WOFF_W-1:0]  w_even, w_odd;
  logic signed [PAIR_W-1:0]  p_even, p_odd;
  logic                      close;
  logic                      accept;

  assign in_stall_o = qstat_i.full;
  assign accept     = in_valid_i && !qstat_i.full;
  assign wr_en_o    = accept;

  always_comb begin
    w_even = $signed({1'b0, weight_pair_i[3:0]}) - NIB_OFFSET;
    w_odd  = $signed({1'b0, weight_pair_i[7:4]}) - NIB_OFFSET;
    p_even = PAIR_W'(w_even) * PAIR_W'(act_even_i);
    p_odd  = PAIR_W'(w_odd) * PAIR_W'(act_odd_i);
    close  = last_of_row_i || (cnt_q == CNT_W'(BPB - 1));
  end

  always_comb begin
    wr_data_o.pair_sum = p_even + p_odd;
    wr_data_o.scale    = block_scale_i;
    wr_data_o.close    = close;
    wr_data_o.last     = last_of_row_i;
  end

  // advance the byte count; restart it when the block closes
  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = close ? '0 : cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/core/i4dq_queue.sv]
// Short queue between front and back of the int4 block dequant dot product.
// Depends on i4dq_pkg.
module i4dq_queue import i4dq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wr_en_i,
  input  i4dq_entry_t wr_data_i,
  input  logic        rd_en_i,
  output i4dq_entry_t rd_data_o,
  output i4dq_qstat_t qstat_o
);

  i4dq_entry_t       mem_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign qstat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign qstat_o.empty = (cnt_q == '0);
  assign rd_data_o     = mem_q[rptr_q];

  always_comb begin
    wptr_d = wr_en_i ? wptr_q + QPTR_W'(1) : wptr_q;
    rptr_d = rd_en_i ? rptr_q + QPTR_W'(1) : rptr_q;
    cnt_d  = cnt_q + QCNT_W'(wr_en_i) - QCNT_W'(rd_en_i);
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

[rtl/core/i4dq_back.sv]
// Back end: block sum, block scaling multiply, row total and the output register.
// Depends on i4dq_pkg; drains i4dq_queue.
module i4dq_back import i4dq_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  i4dq_qstat_t             qstat_i,
  input  i4dq_entry_t             rd_data_i,
  output logic                    rd_en_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [ROW_W-1:0] dot_result_o
);

  logic                     adv;
  logic                     pop;
  logic signed [BSUM_W-1:0] bsum_q, bsum_d, bsum_sat;
  logic signed [BSUM_W:0]   bsum_wide;
  logic                     a_v_q, a_v_d;
  logic                     a_last_q;
  logic signed [BSUM_W-1:0] a_bsum_q;
  logic signed [ACT_W-1:0]  a_scale_q;
  logic                     b_v_q, b_v_d;
  logic                     b_last_q;
  logic signed [PROD_W-1:0] b_prod_q;
  logic signed [ROW_W-1:0]  row_q, row_d, row_sat;
  logic signed [ROW_W:0]    row_wide;
  logic                     out_v_q, out_v_d;
  logic signed [ROW_W-1:0]  out_q;

  // hold the whole back pipe while a finished result waits
  assign adv     = !(out_v_q && out_stall_i);
  assign pop     = adv && !qstat_i.empty;
  assign rd_en_o = pop;

  always_comb begin
    bsum_wide = {bsum_q[BSUM_W-1], bsum_q} + (BSUM_W + 1)'(rd_data_i.pair_sum);
    if (bsum_wide[BSUM_W] != bsum_wide[BSUM_W-1]) begin
      bsum_sat = bsum_wide[BSUM_W] ? {1'b1, {(BSUM_W-1){1'b0}}} : {1'b0, {(BSUM_W-1){1'b1}}};
    end else begin
      bsum_sat = bsum_wide[BSUM_W-1:0];
    end
    bsum_d = bsum_q;
    if (pop) begin
      bsum_d = rd_data_i.close ? '0 : bsum_sat;
    end
  end

  always_comb begin
    row_wide = {row_q[ROW_W-1], row_q} + (ROW_W + 1)'(b_prod_q);
    if (row_wide[ROW_W] != row_wide[ROW_W-1]) begin
      row_sat = row_wide[ROW_W] ? {1'b1, {(ROW_W-1){1'b0}}} : {1'b0, {(ROW_W-1){1'b1}}};
    end else begin
      row_sat = row_wide[ROW_W-1:0];
    end
    row_d = row_q;
    if (adv && b_v_q) begin
      row_d = b_last_q ? '0 : row_sat;
    end
  end

  always_comb begin
    a_v_d   = adv ? (pop && rd_data_i.close) : a_v_q;
    b_v_d   = adv ? a_v_q : b_v_q;
    out_v_d = adv ? (b_v_q && b_last_q) : out_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (pop && rd_data_i.close) begin
      a_bsum_q  <= bsum_sat;
      a_scale_q <= rd_data_i.scale;
      a_last_q  <= rd_data_i.last;
    end
    if (adv && a_v_q) begin
      b_prod_q <= PROD_W'(a_bsum_q) * PROD_W'(a_scale_q);
      b_last_q <= a_last_q;
    end
    if (adv && b_v_q && b_last_q) begin
      out_q <= row_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsum_q  <= '0;
      row_q   <= '0;
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      bsum_q  <= bsum_d;
      row_q   <= row_d;
      a_v_q   <= a_v_d;
      b_v_q   <= b_v_d;
      out_v_q <= out_v_d;
    end
  end

  assign out_valid_o  = out_v_q;
  assign dot_result_o = out_q;

endmodule

[rtl/core/i4dq_checker.sv]
// Port-level checker for the int4 block dequant dot product, bound to the top level.
// Depends on i4dq_pkg and int4_block_dequant_dot_product_defines.svh.
`include "int4_block_dequant_dot_product_defines.svh"

module i4dq_checker import i4dq_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    last_of_row_i,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [ROW_W-1:0] dot_result_o
);

  localparam int PEND_MAX = QDEPTH + 3;

  logic       in_acc, out_acc;
  logic [3:0] pend_q, pend_d;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // count rows accepted whose result has not yet been taken
  always_comb begin
    pend_d = pend_q + 4'(in_acc && last_of_row_i) - 4'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  `I4DQ_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(dot_result_o), "stalled result changed or dropped")
  `I4DQ_ASSERT_IMPL(a_no_invented, out_valid_o, pend_q != 4'd0, "result shown with no row outstanding")
  `I4DQ_ASSERT_IMPL(a_pend_bound, 1'b1, pend_q <= 4'(PEND_MAX), "more rows outstanding than the block can hold")

endmodule

bind int4_block_dequant_dot_product i4dq_checker u_i4dq_checker (.*);

[test/int4_block_dequant_dot_product_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for int4_block_dequant_dot_product: predicts each row's dot product
// from the accepted items and compares every result the block emits. Depends on i4dq_pkg.
module int4_block_dequant_dot_product_tb;
  import i4dq_pkg::*;

  // Bias that turns a raw nibble into a signed weight from -8 to 7.
  localparam longint WEIGHT_BIAS = 8;
  // Saturation bounds of the open block sum and of the row total.
  localparam longint BSUM_HI = (longint'(1) <<< (BSUM_W - 1)) - 1;
  localparam longint BSUM_LO = -(longint'(1) <<< (BSUM_W - 1));
  localparam longint ROW_HI  = (longint'(1) <<< (ROW_W - 1)) - 1;
  localparam longint ROW_LO  = -(longint'(1) <<< (ROW_W - 1));

  localparam logic signed [ACT_W-1:0] ACT_MIN = 16'sh8000;
  localparam logic signed [ACT_W-1:0] ACT_MAX = 16'sh7fff;

  // Full-scale blocks of the first sign before the row swings the other way.
  localparam int BIG_BLOCKS   = 1;
  // Drain margin after the last owed row total has arrived.
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 400000;

  logic                    clk_i          = 1'b0;
  logic                    rst_ni         = 1'b0;
  logic                    in_valid_i     = 1'b0;
  logic                    in_stall_o;
  logic [7:0]              weight_pair_i  = '0;
  logic signed [ACT_W-1:0] act_even_i     = '0;
  logic signed [ACT_W-1:0] act_odd_i      = '0;
  logic signed [ACT_W-1:0] block_scale_i  = '0;
  logic                    last_of_row_i  = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i    = 1'b0;
  logic signed [ROW_W-1:0] dot_result_o;

  // Predictor state: open block sum, bytes taken in that block, row total so far.
  longint blk_sum   = 0;
  int     blk_bytes = 0;
  longint row_acc   = 0;

  // Row totals still owed by the block, oldest first.
  logic signed [ROW_W-1:0] pending_dots[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int4_block_dequant_dot_product DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .weight_pair_i(weight_pair_i),
    .act_even_i   (act_even_i),
    .act_odd_i    (act_odd_i),
    .block_scale_i(block_scale_i),
    .last_of_row_i(last_of_row_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .dot_result_o (dot_result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: stall at random with the current percentage.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic longint clamp_range(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the predictor by one accepted item; queue the row total on the last one.
  function automatic void accumulate_dot(input logic [7:0] wp,
                                         input logic signed [ACT_W-1:0] ae,
                                         input logic signed [ACT_W-1:0] ao,
                                         input logic signed [ACT_W-1:0] sc,
                                         input logic last);
    longint w_even;
    longint w_odd;
    w_even = longint'(wp[3:0]) - WEIGHT_BIAS;
    w_odd  = longint'(wp[7:4]) - WEIGHT_BIAS;
    blk_sum = clamp_range(blk_sum + w_even * longint'(ae) + w_odd * longint'(ao),
                          BSUM_LO, BSUM_HI);
    blk_bytes++;
    // Close the block on a full byte count or at the end of the row (short final block).
    if (blk_bytes >= BPB || last) begin
      row_acc   = clamp_range(row_acc + blk_sum * longint'(sc), ROW_LO, ROW_HI);
      blk_sum   = 0;
      blk_bytes = 0;
    end
    if (last) begin
      pending_dots.push_back(row_acc[ROW_W-1:0]);
      row_acc = 0;
    end
  endfunction

  // Mostly random 16-bit values, with the edges of the range and small values near zero drawn often.
  function automatic logic signed [ACT_W-1:0] pick_fixed();
    case ($urandom_range(7))
      0:       return ACT_MIN;
      1:       return ACT_MAX;
      2:       return (ACT_W)'($urandom_range(3)) - 16'sd1;
      default: return (ACT_W)'($urandom());
    endcase
  endfunction

  // Send one item: idle at random first, hold it until accepted, then predict.
  // Decide acceptance at the falling edge, where stall and valid are settled.
  task automatic send_item(input logic [7:0] wp,
                           input logic signed [ACT_W-1:0] ae,
                           input logic signed [ACT_W-1:0] ao,
                           input logic signed [ACT_W-1:0] sc,
                           input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      // Idle cycles carry junk payload; the block must ignore it.
      in_valid_i    <= 1'b0;
      weight_pair_i <= 8'($urandom());
      act_even_i    <= (ACT_W)'($urandom());
      act_odd_i     <= (ACT_W)'($urandom());
      block_scale_i <= (ACT_W)'($urandom());
      last_of_row_i <= 1'($urandom());
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    weight_pair_i <= wp;
    act_even_i    <= ae;
    act_odd_i     <= ao;
    block_scale_i <= sc;
    last_of_row_i <= last;
    @(negedge clk_i);
    while (in_stall_o !== 1'b0) @(negedge clk_i);
    @(posedge clk_i);
    accumulate_dot(wp, ae, ao, sc, last);
  endtask

  // Stop sending and hold off until every owed row total has arrived.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_dots.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Result checker: compare each accepted result with the oldest owed row total.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o !== 1'b0 && !out_stall_i) begin
      if (pending_dots.size() == 0) begin
        $error("dot_result: expected none, got %0d", dot_result_o);
        mismatch_count++;
      end else begin
        if (dot_result_o !== pending_dots[0]) begin
          $error("dot_result: expected %0d, got %0d", pending_dots[0], dot_result_o);
          mismatch_count++;
        end
        void'(pending_dots.pop_front());
      end
    end
  end

  // Single-item rows at the corners of every field, plus zero weights and a zero scale: each closes a one-byte block.
  task automatic test_field_extremes();
    send_item(8'h00, ACT_MIN, ACT_MIN, ACT_MIN, 1'b1);
    send_item(8'hff, ACT_MAX, ACT_MAX, ACT_MAX, 1'b1);
    send_item(8'h0f, ACT_MIN, ACT_MAX, ACT_MAX, 1'b1);
    send_item(8'hf0, ACT_MAX, ACT_MIN, ACT_MIN, 1'b1);
    // Both nibbles at the bias: zero weights.
    send_item(8'h88, ACT_MAX, ACT_MIN, ACT_MAX, 1'b1);
    // Zero scale wipes the block.
    send_item(8'ha5, 16'sh1234, -16'sh4321, 16'sh0000, 1'b1);
  endtask

  // One full block closed by count with its own scale, then a short final block.
  task automatic test_block_boundaries();
    int i;
    logic signed [ACT_W-1:0] sc;
    for (i = 0; i < BPB + 2; i++) begin
      sc = (i == BPB - 1) ? 16'sh0123 : (i == BPB + 1) ? -16'sh0456 : pick_fixed();
      send_item(8'($urandom()), pick_fixed(), pick_fixed(), sc, i == BPB + 1);
    end
    // Drain: hold the sender until the block has returned everything.
    wait_for_results();
  endtask

  // Full-scale blocks of one sign, then of the other, so the row total
  // swings far past zero each way on the widest block sums.
  task automatic test_full_scale_blocks();
    int b;
    int i;
    logic signed [ACT_W-1:0] sc;
    for (b = 0; b < BIG_BLOCKS + 4; b++) begin
      sc = (b < BIG_BLOCKS) ? ACT_MAX : ACT_MIN;
      for (i = 0; i < BPB; i++)
        send_item(8'h00, ACT_MIN, ACT_MIN, sc, b == BIG_BLOCKS + 3 && i == BPB - 1);
    end
    for (b = 0; b < BIG_BLOCKS + 2; b++) begin
      sc = (b < BIG_BLOCKS) ? ACT_MIN : ACT_MAX;
      for (i = 0; i < BPB; i++)
        send_item(8'h00, ACT_MIN, ACT_MIN, sc, b == BIG_BLOCKS + 1 && i == BPB - 1);
    end
    wait_for_results();
  endtask

  // Random rows of random content; lengths are short, exact block multiples or longer.
  task automatic test_random_rows(input int n_items, input int idle_pct, input int stall_pct);
    int sent;
    int row_len;
    int i;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(4))
        0, 1:    row_len = $urandom_range(BPB - 1, 1);
        2:       row_len = BPB * $urandom_range(3, 1);
        default: row_len = $urandom_range(4 * BPB, BPB + 1);
      endcase
      for (i = 0; i < row_len; i++)
        send_item(8'($urandom()), pick_fixed(), pick_fixed(), pick_fixed(), i == row_len - 1);
      sent += row_len;
    end
    wait_for_results();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_field_extremes();
    test_block_boundaries();
    test_full_scale_blocks();
    test_random_rows(100, 0, 0);
    test_random_rows(100, 60, 0);
    test_random_rows(100, 0, 60);
    test_random_rows(100, 21, 21);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
